// File: rtl/jlvb_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the jerk-limited velocity bound.
package jlvb_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int VALUE_BITS = 24;
  localparam int CFG_BITS   = 16;
  localparam int IDX_BITS   = 8;
  localparam int X0_BITS    = 32;
  localparam int V0SQ_BITS  = 64;

  // Linear term shift: << (FRAC_BITS + 1) then >> 8
  localparam int LIN_SHIFT  = FRAC_BITS + 1 - 8;

  // Square-root datapath
  localparam int SQ_RAD_BITS  = 65;
  localparam int SQ_ROOT_BITS = 33;
  localparam int SQ_W         = 67;

  // Cube-root datapath
  localparam int CB_RAD_BITS  = 75;
  localparam int CB_ROOT_BITS = 25;
  localparam int CB_SQ_BITS   = 50;
  localparam int CB_W         = 78;

  localparam int ROOT_STAGES  = SQ_ROOT_BITS;

  localparam logic [IDX_BITS-1:0] REG_ACCEL = IDX_BITS'(0);
  localparam logic [IDX_BITS-1:0] REG_JERK  = IDX_BITS'(1);
  localparam logic [CFG_BITS-1:0] CFG_RESET = {CFG_BITS{1'b1}};

  // Limits and derived crossover, as the datapath sees them
  typedef struct packed {
    logic [CFG_BITS-1:0]  accel;
    logic [CFG_BITS-1:0]  jerk;
    logic [X0_BITS-1:0]   x0;
    logic [V0SQ_BITS-1:0] v0sq;
  } lim_t;

  // Radicands handed from the front end to the root pipeline
  typedef struct packed {
    logic                   region;
    logic [SQ_RAD_BITS-1:0] sq_rad;
    logic [CB_RAD_BITS-1:0] cb_rad;
  } rad_t;

  // Partial state of both root extractions
  typedef struct packed {
    logic                    region;
    logic [SQ_RAD_BITS-1:0]  sq_rem;
    logic [SQ_ROOT_BITS-1:0] sq_root;
    logic [CB_RAD_BITS-1:0]  cb_rem;
    logic [CB_ROOT_BITS-1:0] cb_root;
    logic [CB_SQ_BITS-1:0]   cb_sq;
  } root_st_t;

endpackage

// File: rtl/jlvb_dist_if.sv
`timescale 1ns / 1ps
// Distance input channel.
interface jlvb_dist_if;
  logic                           valid;
  logic                           ready;
  logic [jlvb_pkg::VALUE_BITS-1:0] distance;

  modport source(output valid, distance, input ready);
  modport sink(input valid, distance, output ready);
endinterface

// File: rtl/jlvb_speed_if.sv
`timescale 1ns / 1ps
// Speed result channel.
interface jlvb_speed_if;
  logic                           valid;
  logic                           ready;
  logic [jlvb_pkg::VALUE_BITS-1:0] max_speed;
  logic                           jerk_region;
  logic                           saturated;

  modport source(output valid, max_speed, jerk_region, saturated, input ready);
  modport sink(input valid, max_speed, jerk_region, saturated, output ready);
endinterface

// File: rtl/jlvb_cfg_if.sv
`timescale 1ns / 1ps
// Configuration write channel.
interface jlvb_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [jlvb_pkg::IDX_BITS-1:0] index;
  logic [jlvb_pkg::CFG_BITS-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// File: rtl/jlvb_derive.sv
`timescale 1ns / 1ps
// Limit registers and sequencer that derives the crossover distance and speed.
module jlvb_derive (
  input  logic            clk,
  input  logic            rst,
  jlvb_cfg_if.sink        cfg,
  output logic            busy,
  output jlvb_pkg::lim_t  lim
);

  typedef enum logic [9:0] {
    ST_IDLE = 10'b0000000001,
    ST_SQ   = 10'b0000000010,
    ST_CUBE = 10'b0000000100,
    ST_DIV  = 10'b0000001000,
    ST_XSQ  = 10'b0000010000,
    ST_PLO  = 10'b0000100000,
    ST_PHI  = 10'b0001000000,
    ST_SUM  = 10'b0010000000,
    ST_CBRT = 10'b0100000000,
    ST_VSQ  = 10'b1000000000
  } state_t;

  state_t       state;
  logic [15:0]  accel;
  logic [15:0]  jerk;
  logic [31:0]  x0;
  logic [63:0]  v0sq;
  logic [31:0]  prod_a;
  logic [31:0]  prod_j;
  logic [63:0]  num;
  logic [45:0]  den;
  logic [46:0]  rem;
  logic [5:0]   div_cnt;
  logic [63:0]  xsq;
  logic [51:0]  part_lo;
  logic [51:0]  part_hi;
  logic [95:0]  crem;
  logic [30:0]  cr;
  logic [61:0]  cr2;
  logic [4:0]   cbit;

  logic         cfg_hit;
  logic [15:0]  cfg_eff;
  logic [46:0]  rem_sh;
  logic [31:0]  x0_sat;
  logic [19:0]  j9;
  logic [6:0]   sh2;
  logic [6:0]   sh3;
  logic [95:0]  cb_delta;
  logic [95:0]  cr_ext;
  logic [95:0]  cr2_ext;

  assign busy      = (state != ST_IDLE);
  assign cfg.ready = (state == ST_IDLE);
  assign cfg_hit   = cfg.valid && cfg.ready &&
                     (cfg.index == jlvb_pkg::REG_ACCEL || cfg.index == jlvb_pkg::REG_JERK);
  // A limit of zero acts as one LSB
  assign cfg_eff   = (cfg.data == 16'd0) ? 16'd1 : cfg.data;

  assign lim.accel = accel;
  assign lim.jerk  = jerk;
  assign lim.x0    = x0;
  assign lim.v0sq  = v0sq;

  // Datapath helpers
  always_comb begin
    rem_sh   = {rem[45:0], num[63]};
    x0_sat   = (|num[63:32]) ? 32'hFFFF_FFFF : num[31:0];
    j9       = {jerk, 3'b000} + 20'(jerk);
    sh2      = {1'b0, cbit, 1'b0};
    sh3      = 7'(cbit) + {1'b0, cbit, 1'b0};
    cr_ext   = 96'(cr);
    cr2_ext  = 96'(cr2);
    cb_delta = (((cr2_ext << 1) + cr2_ext) << cbit) +
               (((cr_ext << 1) + cr_ext) << sh2) +
               (96'd1 << sh3);
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_SQ;
      accel <= jlvb_pkg::CFG_RESET;
      jerk  <= jlvb_pkg::CFG_RESET;
    end else begin
      case (state)
        ST_IDLE: begin
          if (cfg_hit) begin
            if (cfg.index == jlvb_pkg::REG_ACCEL) begin
              accel <= cfg_eff;
            end else begin
              jerk <= cfg_eff;
            end
            state <= ST_SQ;
          end
        end
        ST_SQ: begin
          prod_a <= 32'(accel) * 32'(accel);
          prod_j <= 32'(jerk) * 32'(jerk);
          state  <= ST_CUBE;
        end
        ST_CUBE: begin
          // a^3 << FRAC_BITS over 4608 j^2
          num     <= {48'(prod_a) * 48'(accel), 16'd0};
          den     <= {prod_j, 12'd0} + {3'd0, prod_j, 9'd0} + 46'd0;
          rem     <= '0;
          div_cnt <= '0;
          state   <= ST_DIV;
        end
        ST_DIV: begin
          // Restoring division, one quotient bit per cycle
          if (rem_sh >= {1'b0, den}) begin
            rem <= rem_sh - {1'b0, den};
            num <= {num[62:0], 1'b1};
          end else begin
            rem <= rem_sh;
            num <= {num[62:0], 1'b0};
          end
          div_cnt <= div_cnt + 6'd1;
          if (div_cnt == 6'd63) begin
            state <= ST_XSQ;
          end
        end
        ST_XSQ: begin
          x0    <= x0_sat;
          xsq   <= 64'(x0_sat) * 64'(x0_sat);
          state <= ST_PLO;
        end
        ST_PLO: begin
          part_lo <= 52'(xsq[31:0]) * 52'(j9);
          state   <= ST_PHI;
        end
        ST_PHI: begin
          part_hi <= 52'(xsq[63:32]) * 52'(j9);
          state   <= ST_SUM;
        end
        ST_SUM: begin
          crem  <= ({12'd0, part_hi, 32'd0} + 96'(part_lo)) << 7;
          cr    <= '0;
          cr2   <= '0;
          cbit  <= 5'd30;
          state <= ST_CBRT;
        end
        ST_CBRT: begin
          // Cube root, one bit per cycle
          if (cb_delta <= crem) begin
            crem <= crem - cb_delta;
            cr2  <= 62'(cr2_ext + (cr_ext << (cbit + 5'd1)) + (96'd1 << sh2));
            cr   <= cr | (31'd1 << cbit);
          end
          if (cbit == 5'd0) begin
            state <= ST_VSQ;
          end else begin
            cbit <= cbit - 5'd1;
          end
        end
        ST_VSQ: begin
          v0sq  <= 64'(cr) * 64'(cr);
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  // A limit write always starts a recompute
  a_write_starts: assert property (@(posedge clk) disable iff (rst)
    cfg_hit |=> state == ST_SQ)
    else $error("limit write did not start recompute");
  // Divider finishes into the crossover squaring step
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && div_cnt == 6'd63) |=> state == ST_XSQ)
    else $error("divider did not finish after 64 steps");
  // Limits never hold zero
  a_lim_nonzero: assert property (@(posedge clk) disable iff (rst)
    accel != 16'd0 && jerk != 16'd0)
    else $error("limit register holds zero");
`endif

endmodule

// File: rtl/jlvb_front.sv
`timescale 1ns / 1ps
// Four-stage front end that forms the square and cube radicands.
module jlvb_front (
  input  logic            clk,
  input  logic            rst,
  jlvb_dist_if.sink       remaining,
  input  logic            hold,
  input  jlvb_pkg::lim_t  lim,
  output logic            out_valid,
  input  logic            out_ready,
  output jlvb_pkg::rad_t  out_rad
);

  logic        v1, v2, v3;
  logic        en1, en2, en3, en4;
  logic [23:0] d1;
  logic [23:0] diff1;
  logic        reg1, reg2, reg3;
  logic [47:0] dsq2;
  logic [39:0] lin2;
  logic [63:0] n3;
  logic [64:0] sqrad3;

  // Stall chain: a stage moves when it is empty or the next one moves
  assign en4 = !out_valid || out_ready;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign remaining.ready = en1 && !hold;

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) v1 <= remaining.valid && remaining.ready;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) out_valid <= v3;
    end
  end

  // Stage 1: region test and distance past the crossover
  always_ff @(posedge clk) begin
    if (en1) begin
      d1    <= remaining.distance;
      reg1  <= ({8'd0, remaining.distance} <= lim.x0);
      diff1 <= remaining.distance - lim.x0[23:0];
    end
  end

  // Stage 2: d^2 and (d - x0) * a
  always_ff @(posedge clk) begin
    if (en2) begin
      dsq2 <= 48'(d1) * 48'(d1);
      lin2 <= 40'(diff1) * 40'(lim.accel);
      reg2 <= reg1;
    end
  end

  // Stage 3: d^2 * j and v0^2 + 2a(d - x0)
  always_ff @(posedge clk) begin
    if (en3) begin
      n3     <= 64'(dsq2) * 64'(lim.jerk);
      sqrad3 <= 65'(lim.v0sq) + 65'({lin2, 9'd0});
      reg3   <= reg2;
    end
  end

  // Stage 4: scale by 9 * 2^7
  always_ff @(posedge clk) begin
    if (en4) begin
      out_rad.region <= reg3;
      out_rad.sq_rad <= sqrad3;
      out_rad.cb_rad <= 75'({n3, 10'd0}) + 75'({n3, 7'd0});
    end
  end

endmodule

// File: rtl/jlvb_roots.sv
`timescale 1ns / 1ps
// Pipelined square and cube root, one result bit per stage, and output register.
module jlvb_roots (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  jlvb_pkg::rad_t  in_rad,
  jlvb_speed_if.source    speed
);

  localparam int N = jlvb_pkg::ROOT_STAGES;

  jlvb_pkg::root_st_t st  [0:N];
  logic               vld [0:N];
  logic               en  [1:N+1];
  logic [jlvb_pkg::SQ_ROOT_BITS-1:0] sq_fin;
  logic [jlvb_pkg::CB_ROOT_BITS-1:0] cb_fin;

  // Stage zero: fresh radicands, roots at zero
  always_comb begin
    vld[0]        = in_valid;
    st[0].region  = in_rad.region;
    st[0].sq_rem  = in_rad.sq_rad;
    st[0].sq_root = '0;
    st[0].cb_rem  = in_rad.cb_rad;
    st[0].cb_root = '0;
    st[0].cb_sq   = '0;
  end

  assign en[N+1]  = !speed.valid || speed.ready;
  assign in_ready = en[1];

  for (genvar k = 1; k <= N; k++) begin : g_stage
    localparam int SB = N - k;
    jlvb_pkg::root_st_t nxt;
    logic [jlvb_pkg::SQ_W-1:0] sq_d;

    assign en[k] = !vld[k] || en[k+1];

    // Square root bit SB
    always_comb begin
      nxt  = st[k-1];
      sq_d = (jlvb_pkg::SQ_W'(st[k-1].sq_root) << (SB + 1)) +
             (jlvb_pkg::SQ_W'(1) << (2 * SB));
      if (sq_d <= jlvb_pkg::SQ_W'(st[k-1].sq_rem)) begin
        nxt.sq_rem  = jlvb_pkg::SQ_RAD_BITS'(jlvb_pkg::SQ_W'(st[k-1].sq_rem) - sq_d);
        nxt.sq_root = st[k-1].sq_root | (jlvb_pkg::SQ_ROOT_BITS'(1) << SB);
      end
    end

    if (k <= jlvb_pkg::CB_ROOT_BITS) begin : g_cb
      localparam int CB = jlvb_pkg::CB_ROOT_BITS - k;
      logic [jlvb_pkg::CB_W-1:0] cr;
      logic [jlvb_pkg::CB_W-1:0] cr2;
      logic [jlvb_pkg::CB_W-1:0] cb_d;
      jlvb_pkg::root_st_t nxt_cb;

      // Cube root bit CB
      always_comb begin
        cr     = jlvb_pkg::CB_W'(st[k-1].cb_root);
        cr2    = jlvb_pkg::CB_W'(st[k-1].cb_sq);
        cb_d   = (((cr2 << 1) + cr2) << CB) + (((cr << 1) + cr) << (2 * CB)) +
                 (jlvb_pkg::CB_W'(1) << (3 * CB));
        nxt_cb = nxt;
        if (cb_d <= jlvb_pkg::CB_W'(st[k-1].cb_rem)) begin
          nxt_cb.cb_rem  = jlvb_pkg::CB_RAD_BITS'(jlvb_pkg::CB_W'(st[k-1].cb_rem) - cb_d);
          nxt_cb.cb_sq   = jlvb_pkg::CB_SQ_BITS'(cr2 + (cr << (CB + 1)) +
                                                 (jlvb_pkg::CB_W'(1) << (2 * CB)));
          nxt_cb.cb_root = st[k-1].cb_root | (jlvb_pkg::CB_ROOT_BITS'(1) << CB);
        end
      end

      always_ff @(posedge clk) begin
        if (en[k]) st[k] <= nxt_cb;
      end
    end else begin : g_pass
      always_ff @(posedge clk) begin
        if (en[k]) st[k] <= nxt;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en[k]) begin
        vld[k] <= vld[k-1];
      end
    end
  end

  // Output register: branch select and saturation
  assign sq_fin = st[N].sq_root;
  assign cb_fin = st[N].cb_root;

  always_ff @(posedge clk) begin
    if (rst) begin
      speed.valid <= 1'b0;
    end else if (en[N+1]) begin
      speed.valid <= vld[N];
    end
  end

  always_ff @(posedge clk) begin
    if (en[N+1]) begin
      speed.jerk_region <= st[N].region;
      if (st[N].region) begin
        speed.saturated <= cb_fin[24];
        speed.max_speed <= cb_fin[24] ? 24'hFF_FFFF : cb_fin[23:0];
      end else begin
        speed.saturated <= |sq_fin[32:24];
        speed.max_speed <= (|sq_fin[32:24]) ? 24'hFF_FFFF : sq_fin[23:0];
      end
    end
  end

endmodule

// File: rtl/jerk_limited_velocity_bound.sv
`timescale 1ns / 1ps
// Top level of the jerk-limited velocity bound.
//
// Channels: remaining carries one distance (unsigned Q8.16) per transaction;
// speed returns one result per distance, in order: max_speed (Q8.16,
// saturated), jerk_region and saturated. cfg writes the acceleration limit
// (index 0) or the jerk limit (index 1), both unsigned Q8.8; a zero limit
// acts as one LSB and other indexes are ignored.
// After reset or a limit write a sequencer derives the crossover distance
// and speed: a 64-step restoring divider and a 31-step cube root dominate.
// remaining.ready and cfg.ready stay low meanwhile. Limits must be written
// only when no distance is in flight; the block itself does not enforce this.
// A result is offered once its distance has passed four front-end stages
// (squares, products, radicands), 33 root stages that each produce one bit
// of the square root, the leading ones also one bit of the 25-bit cube
// root, and an output register. Throughput is one distance per cycle while
// speed is not stalled and no derivation runs. Every stage advances when it
// is empty or its successor advances, so a stall on speed backs up the pipe
// without loss, and bubbles are squeezed out while the receiver waits.
module jerk_limited_velocity_bound (
  input  logic          clk,
  input  logic          rst,
  jlvb_dist_if.sink     remaining,
  jlvb_speed_if.source  speed,
  jlvb_cfg_if.sink      cfg
);

  jlvb_pkg::lim_t lim;
  jlvb_pkg::rad_t rad;
  logic           busy;
  logic           rad_valid;
  logic           rad_ready;

  jlvb_derive u_derive (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .busy (busy),
    .lim  (lim)
  );

  jlvb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .remaining (remaining),
    .hold      (busy),
    .lim       (lim),
    .out_valid (rad_valid),
    .out_ready (rad_ready),
    .out_rad   (rad)
  );

  jlvb_roots u_roots (
    .clk      (clk),
    .rst      (rst),
    .in_valid (rad_valid),
    .in_ready (rad_ready),
    .in_rad   (rad),
    .speed    (speed)
  );

`ifndef ASSERT_OFF
  // No distance is taken while the crossover is being derived
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !remaining.ready)
    else $error("distance accepted during recompute");
  // A saturated result shows full scale
  a_sat_full: assert property (@(posedge clk) disable iff (rst)
    (speed.valid && speed.saturated) |-> (&speed.max_speed))
    else $error("saturated result not at full scale");
  // A stalled radicand transaction holds its region flag
  a_rad_hold: assert property (@(posedge clk) disable iff (rst)
    (rad_valid && !rad_ready) |=> (rad_valid && $stable(rad.region)))
    else $error("radicand lost while stalled");
`endif

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for the jerk-limited velocity bound: predicts each speed and compares.
module tb_top;

  localparam logic [jlvb_pkg::IDX_BITS-1:0] REG_BAD = jlvb_pkg::IDX_BITS'(7);

  logic clk = 1'b0;
  logic rst = 1'b1;

  jlvb_dist_if  dist_ch();
  jlvb_speed_if speed_ch();
  jlvb_cfg_if   cfg_ch();

  jerk_limited_velocity_bound DUT (
    .clk(clk), .rst(rst), .remaining(dist_ch.sink), .speed(speed_ch.source),
    .cfg(cfg_ch.sink)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  typedef struct {
    logic [jlvb_pkg::VALUE_BITS-1:0] speed;
    logic                            region;
    logic                            sat;
  } speed_res_t;

  // Shadow of the limits and the derived crossover
  logic [jlvb_pkg::CFG_BITS-1:0] accel_q, jerk_q;
  logic [63:0]         x0_q, v0_q;
  speed_res_t          pending_speeds[$];
  int                  mism_cnt = 0;
  int                  res_cnt = 0;
  int                  jerk_res_cnt = 0;
  int                  sat_res_cnt = 0;
  int                  sent_cnt = 0;
  int                  rx_hold = 0;
  int                  rx_wait = 0;

  function automatic logic [63:0] eff_lim(logic [jlvb_pkg::CFG_BITS-1:0] r);
    return (r == 0) ? 64'd1 : 64'(r);
  endfunction

  function automatic logic [63:0] floor_cbrt(logic [127:0] x);
    logic [63:0] r;
    logic [63:0] t;
    r = 0;
    for (int b = 41; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (128'(t) * t * t <= x) r = t;
    end
    return r;
  endfunction

  function automatic logic [63:0] floor_sqrt(logic [127:0] x);
    logic [63:0] r;
    logic [63:0] t;
    r = 0;
    for (int b = 63; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (128'(t) * t <= x) r = t;
    end
    return r;
  endfunction

  function automatic logic [63:0] jerk_branch_speed(logic [63:0] d);
    logic [127:0] n;
    n = 128'(d) * d * (64'd9 * eff_lim(jerk_q));
    n = (n << jlvb_pkg::FRAC_BITS) >> 9;
    return floor_cbrt(n);
  endfunction

  task automatic derive_crossover();
    logic [127:0] num;
    logic [127:0] q;
    logic [63:0]  a, j, v;
    a = eff_lim(accel_q);
    j = eff_lim(jerk_q);
    num = (128'(a) * a * a) << jlvb_pkg::FRAC_BITS;
    q = num / (128'd4608 * j * j);
    x0_q = (q > 128'hFFFF_FFFF) ? 64'hFFFF_FFFF : q[63:0];
    v = jerk_branch_speed(x0_q);
    v0_q = (v > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : v;
  endtask

  function automatic speed_res_t predict_speed(logic [jlvb_pkg::VALUE_BITS-1:0] dval);
    speed_res_t   r;
    logic [63:0]  d, v;
    logic [127:0] term;
    d = 64'(dval);
    if (d > x0_q) begin
      term = 128'(d - x0_q) * eff_lim(accel_q);
      term = (term << (jlvb_pkg::FRAC_BITS + 1)) >> 8;
      v = floor_sqrt(128'(v0_q) * v0_q + term);
      r.region = 1'b0;
    end else begin
      v = jerk_branch_speed(d);
      r.region = 1'b1;
    end
    if (v > 64'((1 << jlvb_pkg::VALUE_BITS) - 1)) begin
      r.speed = '1;
      r.sat = 1'b1;
    end else begin
      r.speed = v[jlvb_pkg::VALUE_BITS-1:0];
      r.sat = 1'b0;
    end
    return r;
  endfunction

  // Result side: ready drops for a randomly drawn gap after each accepted result, plus one long hold-off
  initial begin
    speed_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        speed_ch.ready <= 1'b0;
        rx_hold--;
      end else if (rx_wait > 0) begin
        speed_ch.ready <= 1'b0;
        rx_wait--;
      end else begin
        speed_ch.ready <= 1'b1;
      end
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    speed_res_t e;
    if (!rst && speed_ch.valid && speed_ch.ready) begin
      res_cnt++;
      rx_wait = $urandom_range(0, 4);
      if (pending_speeds.size() == 0) begin
        mism_cnt++;
        if (mism_cnt <= 10) $display("unexpected result speed=%h", speed_ch.max_speed);
      end else begin
        e = pending_speeds.pop_front();
        if (speed_ch.max_speed != e.speed || speed_ch.jerk_region != e.region ||
            speed_ch.saturated != e.sat) begin
          mism_cnt++;
          if (mism_cnt <= 10)
            $display("mismatch: expected %h/%b/%b got %h/%b/%b", e.speed, e.region, e.sat,
                     speed_ch.max_speed, speed_ch.jerk_region, speed_ch.saturated);
        end
        if (e.region) jerk_res_cnt++;
        if (e.sat) sat_res_cnt++;
      end
    end
  end

  // Send one distance, idling for the given gap first
  task automatic send_distance(logic [jlvb_pkg::VALUE_BITS-1:0] d, int gap);
    if (gap > 0) begin
      dist_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    dist_ch.valid <= 1'b1;
    dist_ch.distance <= d;
    @(posedge clk);
    while (!dist_ch.ready) @(posedge clk);
    pending_speeds.push_back(predict_speed(d));
    sent_cnt++;
    @(negedge clk);
  endtask

  // Waits for a negedge before driving, so valid drops between back-to-back writes
  task automatic write_limit(logic [jlvb_pkg::IDX_BITS-1:0] idx,
                             logic [jlvb_pkg::CFG_BITS-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    if (idx == jlvb_pkg::REG_ACCEL) accel_q = val;
    else if (idx == jlvb_pkg::REG_JERK) jerk_q = val;
    if (idx == jlvb_pkg::REG_ACCEL || idx == jlvb_pkg::REG_JERK) derive_crossover();
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    dist_ch.valid <= 1'b0;
    while (pending_speeds.size() != 0) @(negedge clk);
    repeat (5) @(negedge clk);
  endtask

  function automatic logic [jlvb_pkg::VALUE_BITS-1:0] rand_distance();
    int sel;
    logic [63:0] d;
    sel = $urandom_range(0, 9);
    if (sel < 3) begin
      return jlvb_pkg::VALUE_BITS'($urandom);
    end else if (sel < 7) begin
      // cluster around the crossover
      d = x0_q + 64'($signed($urandom_range(0, 2000)) - 1000);
      return (x0_q > 64'hFF_FFFF) ? jlvb_pkg::VALUE_BITS'($urandom) :
                                    jlvb_pkg::VALUE_BITS'(d);
    end else begin
      return jlvb_pkg::VALUE_BITS'($urandom) >> $urandom_range(0, 23);
    end
  endfunction

  typedef struct {
    logic [jlvb_pkg::VALUE_BITS-1:0] d;
    logic                            chk;
    logic [jlvb_pkg::VALUE_BITS-1:0] speed;
    logic                            region;
    logic                            sat;
  } dist_row_t;

  dist_row_t dir_rows[] = '{
    '{24'h000000, 1'b1, 24'h000000, 1'b1, 1'b0},
    '{24'h000001, 1'b0, 24'h0, 1'b0, 1'b0},
    '{24'hFFFFFF, 1'b0, 24'h0, 1'b0, 1'b0},
    '{24'h0E38E3, 1'b0, 24'h0, 1'b0, 1'b0},
    '{24'h0E38E4, 1'b0, 24'h0, 1'b0, 1'b0},
    '{24'h800000, 1'b0, 24'h0, 1'b0, 1'b0},
    '{24'h555555, 1'b0, 24'h0, 1'b0, 1'b0},
    '{24'hAAAAAA, 1'b0, 24'h0, 1'b0, 1'b0},
    '{24'h010000, 1'b0, 24'h0, 1'b0, 1'b0}
  };

  // Limit settings visited by the random phases
  logic [jlvb_pkg::CFG_BITS-1:0] acc_set[] =
    '{16'h0000, 16'h0001, 16'hFFFF, 16'h0100, 16'h1234, 16'h0400};
  logic [jlvb_pkg::CFG_BITS-1:0] jrk_set[] =
    '{16'h0001, 16'h0000, 16'hFFFF, 16'h0100, 16'h0080, 16'h2000};

  // Stimulus
  initial begin
    speed_res_t e;
    dist_ch.valid = 1'b0;
    dist_ch.distance = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    accel_q = jlvb_pkg::CFG_RESET;
    jerk_q = jlvb_pkg::CFG_RESET;
    derive_crossover();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed rows at reset limits
    foreach (dir_rows[i]) begin
      send_distance(dir_rows[i].d, $urandom_range(0, 4));
      if (dir_rows[i].chk) begin
        e = pending_speeds[$];
        if (e.speed != dir_rows[i].speed || e.region != dir_rows[i].region ||
            e.sat != dir_rows[i].sat) begin
          mism_cnt++;
          $display("table row %0d disagrees with prediction", i);
        end
      end
    end
    wait_drained();

    // Long receiver hold-off while distances keep coming
    rx_hold = 120;
    for (int i = 0; i < 80; i++) send_distance(rand_distance(), 0);
    wait_drained();
    write_limit(REG_BAD, 16'h0002);
    for (int i = 0; i < 6; i++) send_distance(rand_distance(), $urandom_range(0, 4));
    wait_drained();

    // Random phases over several limit settings
    for (int p = 0; p < 6; p++) begin
      write_limit(jlvb_pkg::REG_ACCEL, acc_set[p]);
      write_limit(jlvb_pkg::REG_JERK, jrk_set[p]);
      send_distance(24'h000000, 0);
      send_distance(24'hFFFFFF, 0);
      for (int i = 0; i < 195; i++)
        send_distance(rand_distance(), ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4));
      wait_drained();
    end

    $display("sent %0d distances over 7 limit settings, %0d results checked", sent_cnt,
             res_cnt);
    $display("jerk-region results %0d, saturated results %0d", jerk_res_cnt, sat_res_cnt);
    if (mism_cnt == 0 && pending_speeds.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #3000000;
    $display("status: fail");
    $finish;
  end

endmodule

// File: jerk_limited_velocity_bound.f
rtl/jlvb_pkg.sv
rtl/jlvb_dist_if.sv
rtl/jlvb_speed_if.sv
rtl/jlvb_cfg_if.sv
rtl/jlvb_derive.sv
rtl/jlvb_front.sv
rtl/jlvb_roots.sv
rtl/jerk_limited_velocity_bound.sv
sim/tb_top.sv
